[design/uart_rb_pkg.sv]
// Shared types and constants for the uart ring buffer block.
// Used by the top level and by its port checker; depends on nothing.
package uart_rb_pkg;

    // beat widths on the two stream sides
    localparam int KIND_W      = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    // what one input beat asks for
    typedef enum logic [KIND_W-1:0] {
        KIND_RX_BYTE    = 3'd0,
        KIND_PEEK       = 3'd1,
        KIND_DISCARD    = 3'd2,
        KIND_ADMIT      = 3'd3,
        KIND_FRAME_BYTE = 3'd4,
        KIND_DATA_EMPTY = 3'd5,
        KIND_TX_DONE    = 3'd6
    } t_kind;

    // result beat, lowest field last (packed structs fill from the top)
    typedef struct packed {
        logic [3:0] pad;
        logic       done_irq_enable;
        logic       empty_irq_enable;
        logic [7:0] tx_free;
        logic [7:0] rx_available;
        logic       accepted;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] read_byte;
    } t_out_beat;

endpackage

[design/uart_rx_tx_ring_buffers.sv]
// Top level of the uart ring buffer block: receive ring, transmit ring,
// interrupt enable tracking. Depends on uart_rb_pkg.

// One beat is taken every clock while the result side keeps up; each beat
// gives exactly one result beat, passing first through the input register
// and then through the result register, where the ring memory read is
// registered. Both rings sit in single-write, single-read memories of
// RX_DEPTH and TX_DEPTH bytes addressed by head and tail pointers; all
// pointer and count arithmetic for a beat is combinational between the two registers.
// Memory contents are not cleared at reset: peeking at a receive entry that
// was never written returns an arbitrary byte.
module uart_rx_tx_ring_buffers #(
    parameter int RX_DEPTH = 256,
    parameter int TX_DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input side
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // data_byte [7:0], offset [15:8], amount [23:16]
    input  logic [uart_rb_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // kind [2:0]
    input  logic [uart_rb_pkg::KIND_W-1:0]       i_s_axis_tuser,
    // result side
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // read_byte [7:0], tx_byte [15:8], tx_valid [16], accepted [17],
    // rx_available [25:18], tx_free [33:26], empty_irq_enable [34],
    // done_irq_enable [35], zero [39:36]
    output logic [uart_rb_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import uart_rb_pkg::*;

    localparam int RXW = $clog2(RX_DEPTH);
    localparam int TXW = $clog2(TX_DEPTH);
    localparam int RCW = (RXW > 8) ? RXW : 8;
    localparam int TCW = (TXW > 8) ? TXW : 8;

    // byte distance reduced modulo the receive depth
    typedef logic [RXW-1:0] t_rx_tab [256];

    function automatic t_rx_tab rx_mod_init();
        t_rx_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = RXW'(i % RX_DEPTH);
        end
        return tab;
    endfunction

    localparam t_rx_tab RX_MOD = rx_mod_init();

    // pointer add with wrap, both operands below the depth
    function automatic logic [RXW-1:0] rx_add(input logic [RXW-1:0] p,
                                              input logic [RXW-1:0] d);
        logic [RXW:0] s;
        s = {1'b0, p} + {1'b0, d};
        if (s >= (RXW+1)'(RX_DEPTH)) begin
            s = s - (RXW+1)'(RX_DEPTH);
        end
        return s[RXW-1:0];
    endfunction

    function automatic logic [TXW-1:0] tx_inc(input logic [TXW-1:0] p);
        logic [TXW:0] s;
        s = {1'b0, p} + (TXW+1)'(1);
        if (s >= (TXW+1)'(TX_DEPTH)) begin
            s = s - (TXW+1)'(TX_DEPTH);
        end
        return s[TXW-1:0];
    endfunction

    function automatic logic [RXW-1:0] rx_used(input logic [RXW-1:0] h,
                                               input logic [RXW-1:0] t);
        logic [RXW:0] s;
        s = {1'b0, h} - {1'b0, t};
        if (h < t) begin
            s = s + (RXW+1)'(RX_DEPTH);
        end
        return s[RXW-1:0];
    endfunction

    // free space is depth-1 minus used
    function automatic logic [TXW-1:0] tx_room(input logic [TXW-1:0] h,
                                               input logic [TXW-1:0] t);
        logic [TXW:0] s;
        s = {1'b0, h} - {1'b0, t};
        if (h < t) begin
            s = s + (TXW+1)'(TX_DEPTH);
        end
        s = (TXW+1)'(TX_DEPTH - 1) - s;
        return s[TXW-1:0];
    endfunction

    // ring storage
    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    // input register
    logic       r_in_vld;
    t_kind      r_in_kind;
    logic [7:0] r_in_data;
    logic [7:0] r_in_off;
    logic [7:0] r_in_amt;

    // ring and transmitter state
    logic [RXW-1:0] r_rx_head, n_rx_head;
    logic [RXW-1:0] r_rx_tail, n_rx_tail;
    logic [TXW-1:0] r_tx_head, n_tx_head;
    logic [TXW-1:0] r_tx_tail, n_tx_tail;
    logic           r_sending, n_sending;
    logic [7:0]     r_frame_left, n_frame_left;
    logic           r_empty_on, n_empty_on;
    logic           r_done_on, n_done_on;

    // result register
    logic       r_out_vld;
    logic       r_res_peek, n_res_peek;
    logic       r_res_txv, n_res_txv;
    logic       r_res_byp, n_res_byp;
    logic       r_res_acc, n_res_acc;
    logic [7:0] r_byp_byte;
    logic [7:0] r_rx_rd;
    logic [7:0] r_tx_rd;

    logic           en;
    logic           go;
    logic           rx_we;
    logic           tx_we;
    logic [RXW-1:0] peek_addr;
    logic [RXW-1:0] rx_used_now;
    logic [TXW-1:0] tx_room_now;
    logic [RCW-1:0] rx_used_ext;
    logic [TCW-1:0] tx_room_ext;
    t_out_beat      beat;

    // whole pipeline moves when the result slot is free or being taken
    assign en              = !r_out_vld || i_m_axis_tready;
    assign go              = en && r_in_vld;
    assign o_s_axis_tready = en;

    assign peek_addr = rx_add(r_rx_tail, RX_MOD[r_in_off]);

    // next state for the beat in the input register
    always_comb begin
        n_rx_head    = r_rx_head;
        n_rx_tail    = r_rx_tail;
        n_tx_head    = r_tx_head;
        n_tx_tail    = r_tx_tail;
        n_sending    = r_sending;
        n_frame_left = r_frame_left;
        n_empty_on   = r_empty_on;
        n_done_on    = r_done_on;
        n_res_peek   = 1'b0;
        n_res_txv    = 1'b0;
        n_res_byp    = 1'b0;
        n_res_acc    = 1'b1;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        unique case (r_in_kind)
            KIND_RX_BYTE: begin
                rx_we     = 1'b1;
                n_rx_head = rx_add(r_rx_head, RXW'(1));
            end
            KIND_PEEK: begin
                n_res_peek = 1'b1;
            end
            KIND_DISCARD: begin
                n_rx_tail = rx_add(r_rx_tail, RX_MOD[r_in_amt]);
            end
            KIND_ADMIT: begin
                if (r_in_amt != 8'd0) begin
                    if (r_frame_left != 8'd0
                        || TCW'(r_in_amt) > TCW'(tx_room(r_tx_head, r_tx_tail))) begin
                        n_res_acc = 1'b0;
                    end else begin
                        n_frame_left = r_in_amt;
                    end
                end
            end
            KIND_FRAME_BYTE: begin
                if (r_frame_left != 8'd0) begin
                    tx_we        = 1'b1;
                    n_tx_head    = tx_inc(r_tx_head);
                    n_frame_left = r_frame_left - 8'd1;
                    // last byte of the frame starts an idle transmitter
                    if (r_frame_left == 8'd1 && !r_sending) begin
                        n_sending  = 1'b1;
                        n_res_txv  = 1'b1;
                        n_res_byp  = (r_tx_tail == r_tx_head);
                        n_tx_tail  = tx_inc(r_tx_tail);
                        n_empty_on = 1'b1;
                        n_done_on  = 1'b1;
                    end
                end
            end
            KIND_DATA_EMPTY: begin
                if (r_sending) begin
                    if (r_tx_tail != r_tx_head) begin
                        n_res_txv = 1'b1;
                        n_tx_tail = tx_inc(r_tx_tail);
                    end
                    if (n_tx_tail == r_tx_head) begin
                        n_sending  = 1'b0;
                        n_empty_on = 1'b0;
                    end
                end else begin
                    n_empty_on = 1'b0;
                end
            end
            KIND_TX_DONE: begin
                if (!r_sending) begin
                    n_empty_on = 1'b0;
                    n_done_on  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_rx_head    <= '0;
            r_rx_tail    <= '0;
            r_tx_head    <= '0;
            r_tx_tail    <= '0;
            r_sending    <= 1'b0;
            r_frame_left <= '0;
            r_empty_on   <= 1'b0;
            r_done_on    <= 1'b0;
        end else begin
            if (en) begin
                r_in_vld  <= i_s_axis_tvalid;
                r_out_vld <= r_in_vld;
            end
            if (go) begin
                r_rx_head    <= n_rx_head;
                r_rx_tail    <= n_rx_tail;
                r_tx_head    <= n_tx_head;
                r_tx_tail    <= n_tx_tail;
                r_sending    <= n_sending;
                r_frame_left <= n_frame_left;
                r_empty_on   <= n_empty_on;
                r_done_on    <= n_done_on;
            end
        end
    end

    // input and result payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_kind <= t_kind'(i_s_axis_tuser);
            r_in_data <= i_s_axis_tdata[7:0];
            r_in_off  <= i_s_axis_tdata[15:8];
            r_in_amt  <= i_s_axis_tdata[23:16];
        end
        if (go) begin
            r_res_peek <= n_res_peek;
            r_res_txv  <= n_res_txv;
            r_res_byp  <= n_res_byp;
            r_res_acc  <= n_res_acc;
            r_byp_byte <= r_in_data;
        end
    end

    // receive ring memory
    always_ff @(posedge i_clk) begin
        if (go && rx_we) begin
            rx_mem[r_rx_head] <= r_in_data;
        end
        if (go && n_res_peek) begin
            r_rx_rd <= rx_mem[peek_addr];
        end
    end

    // transmit ring memory, read of the old slot when tail meets head is bypassed
    always_ff @(posedge i_clk) begin
        if (go && tx_we) begin
            tx_mem[r_tx_head] <= r_in_data;
        end
        if (go && n_res_txv) begin
            r_tx_rd <= tx_mem[r_tx_tail];
        end
    end

    // counts follow the state, which holds while the result waits
    assign rx_used_now = rx_used(r_rx_head, r_rx_tail);
    assign tx_room_now = tx_room(r_tx_head, r_tx_tail);
    assign rx_used_ext = RCW'(rx_used_now);
    assign tx_room_ext = TCW'(tx_room_now);

    // result beat
    always_comb begin
        beat                  = '0;
        beat.read_byte        = r_res_peek ? r_rx_rd : 8'd0;
        beat.tx_byte          = !r_res_txv ? 8'd0 : (r_res_byp ? r_byp_byte : r_tx_rd);
        beat.tx_valid         = r_res_txv;
        beat.accepted         = r_res_acc;
        beat.rx_available     = (rx_used_ext > RCW'(255)) ? 8'hFF : rx_used_ext[7:0];
        beat.tx_free          = (tx_room_ext > TCW'(255)) ? 8'hFF : tx_room_ext[7:0];
        beat.empty_irq_enable = r_empty_on;
        beat.done_irq_enable  = r_done_on;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = beat;

endmodule

[design/uart_rb_checker.sv]
// Port-level checks for the uart ring buffer block, bound to its top level.
// Depends on uart_rb_pkg.
module uart_rb_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    input  logic [uart_rb_pkg::OUT_TDATA_W-1:0]  i_m_axis_tdata
);
    import uart_rb_pkg::*;

    t_out_beat beat;
    assign beat = i_m_axis_tdata;

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> i_m_axis_tvalid && $stable(i_m_axis_tdata))
        else $error("result beat changed under stall");

    // reset empties the result slot
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_axis_tvalid)
        else $error("result valid after reset");

    // data-empty enable is only ever set together with transmit-complete
    a_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && beat.empty_irq_enable |-> beat.done_irq_enable)
        else $error("empty enable without done enable");

    // a peeked byte never comes with a send or a rejection
    a_peek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && beat.read_byte != 8'd0 |-> !beat.tx_valid && beat.accepted)
        else $error("peek result mixed with transmit result");

    // no transmit byte without tx_valid
    a_txb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !beat.tx_valid |-> beat.tx_byte == 8'd0)
        else $error("tx byte without tx valid");

endmodule

bind uart_rx_tx_ring_buffers uart_rb_checker u_uart_rb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata)
);

[tb/uart_ring_checker.sv]
// Port checker for the uart ring buffer block: predicts every result beat
// from the accepted input beats and compares them in order.
// Depends on uart_rb_pkg.
module uart_ring_checker
    import uart_rb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input side as seen at the block
    input  logic                   i_in_tvalid,
    input  logic                   i_in_tready,
    // data_byte [7:0], offset [15:8], amount [23:16]
    input  logic [IN_TDATA_W-1:0]  i_in_tdata,
    // kind [2:0]
    input  logic [KIND_W-1:0]      i_in_tuser,
    // result side as seen at the block
    input  logic                   i_out_tvalid,
    input  logic                   i_out_tready,
    // read_byte [7:0], tx_byte [15:8], tx_valid [16], accepted [17],
    // rx_available [25:18], tx_free [33:26], empty_irq_enable [34],
    // done_irq_enable [35], zero [39:36]
    input  logic [OUT_TDATA_W-1:0] i_out_tdata,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    // shadow of the two rings and the transmit control
    logic [7:0] rx_mem [256];
    logic [7:0] rx_wp;
    logic [7:0] rx_rp;
    logic [7:0] tx_mem [256];
    logic [7:0] tx_wp;
    logic [7:0] tx_rp;
    logic       tx_busy;
    logic [7:0] frame_todo;
    logic       empty_en;
    logic       done_en;

    // results still owed by the block, oldest first
    t_out_beat  due_beats [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // free transmit bytes, one slot always kept empty
    function automatic logic [7:0] tx_room();
        return 8'(8'd255 - 8'(tx_wp - tx_rp));
    endfunction

    // apply one input beat to the shadow state and queue its result
    task automatic step_rings(input t_kind kind, input logic [7:0] data,
                              input logic [7:0] offset, input logic [7:0] amount);
        t_out_beat beat;
        beat          = '0;
        beat.accepted = 1'b1;
        case (kind)
            KIND_RX_BYTE: begin
                // no overflow check, a full ring is overwritten
                rx_mem[rx_wp] = data;
                rx_wp++;
            end
            KIND_PEEK: begin
                beat.read_byte = rx_mem[8'(rx_rp + offset)];
            end
            KIND_DISCARD: begin
                rx_rp = 8'(rx_rp + amount);
            end
            KIND_ADMIT: begin
                if (amount != 8'd0) begin
                    if (frame_todo != 8'd0 || amount > tx_room())
                        beat.accepted = 1'b0;
                    else
                        frame_todo = amount;
                end
            end
            KIND_FRAME_BYTE: begin
                if (frame_todo != 8'd0) begin
                    tx_mem[tx_wp] = data;
                    tx_wp++;
                    frame_todo--;
                    // last byte of a frame starts an idle transmitter
                    if (frame_todo == 8'd0 && !tx_busy) begin
                        tx_busy       = 1'b1;
                        beat.tx_byte  = tx_mem[tx_rp];
                        beat.tx_valid = 1'b1;
                        tx_rp++;
                        empty_en      = 1'b1;
                        done_en       = 1'b1;
                    end
                end
            end
            KIND_DATA_EMPTY: begin
                if (tx_busy) begin
                    if (tx_rp != tx_wp) begin
                        beat.tx_byte  = tx_mem[tx_rp];
                        beat.tx_valid = 1'b1;
                        tx_rp++;
                    end
                    if (tx_rp == tx_wp) begin
                        tx_busy  = 1'b0;
                        empty_en = 1'b0;
                    end
                end else begin
                    empty_en = 1'b0;
                end
            end
            KIND_TX_DONE: begin
                if (!tx_busy) begin
                    empty_en = 1'b0;
                    done_en  = 1'b0;
                end
            end
            default: ;
        endcase
        beat.rx_available     = 8'(rx_wp - rx_rp);
        beat.tx_free          = tx_room();
        beat.empty_irq_enable = empty_en;
        beat.done_irq_enable  = done_en;
        due_beats.push_back(beat);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            o_mismatches++;
        end
    endtask

    // results are compared before the input of the same edge is predicted
    always @(posedge i_clk) begin
        t_out_beat got;
        t_out_beat want;
        if (!i_rst_n) begin
            rx_wp      = '0;
            rx_rp      = '0;
            tx_wp      = '0;
            tx_rp      = '0;
            tx_busy    = 1'b0;
            frame_todo = '0;
            empty_en   = 1'b0;
            done_en    = 1'b0;
            due_beats.delete();
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                got = t_out_beat'(i_out_tdata);
                if (due_beats.size() == 0) begin
                    $error("result beat 0x%0h with no result outstanding", i_out_tdata);
                    o_mismatches++;
                end else begin
                    want = due_beats.pop_front();
                    check_field("read_byte", want.read_byte, got.read_byte);
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
                    check_field("accepted", 8'(want.accepted), 8'(got.accepted));
                    check_field("rx_available", want.rx_available, got.rx_available);
                    check_field("tx_free", want.tx_free, got.tx_free);
                    check_field("empty_irq_enable", 8'(want.empty_irq_enable),
                                8'(got.empty_irq_enable));
                    check_field("done_irq_enable", 8'(want.done_irq_enable),
                                8'(got.done_irq_enable));
                    check_field("pad", 8'(want.pad), 8'(got.pad));
                end
            end
            if (i_in_tvalid && i_in_tready)
                step_rings(t_kind'(i_in_tuser), i_in_tdata[7:0], i_in_tdata[15:8],
                           i_in_tdata[23:16]);
        end
        o_outstanding <= due_beats.size();
    end

endmodule

[tb/testbench.sv]
// Top of the uart ring buffer testbench: clock, reset, stimulus and verdict.
// Depends on uart_rb_pkg, uart_rx_tx_ring_buffers and uart_ring_checker.
module testbench;
    import uart_rb_pkg::*;

    localparam int ITEM_COUNT  = 1300;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_AT    = 900;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // data_byte [7:0], offset [15:8], amount [23:16]
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    // kind [2:0]
    logic [KIND_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // read_byte [7:0], tx_byte [15:8], tx_valid [16], accepted [17],
    // rx_available [25:18], tx_free [33:26], empty_irq_enable [34],
    // done_irq_enable [35], zero [39:36]
    logic [OUT_TDATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int n_sent      = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    // receive ring occupancy as far as the stimulus needs it, to keep
    // every peek on an entry that has been written
    logic [7:0] rx_wp = '0;
    logic [7:0] rx_rp = '0;
    logic       rx_written [256];

    always #2 i_clk = ~i_clk;

    uart_rx_tx_ring_buffers i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    uart_ring_checker ring_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_tvalid   (s_tvalid),
        .i_in_tready   (s_tready),
        .i_in_tdata    (s_tdata),
        .i_in_tuser    (s_tuser),
        .i_out_tvalid  (m_tvalid),
        .i_out_tready  (m_tready),
        .i_out_tdata   (m_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    // offer one beat, in bursts with random gaps between them
    task automatic push_item(input t_kind kind, input logic [7:0] data,
                             input logic [7:0] offset, input logic [7:0] amount);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {amount, offset, data};
        s_tuser  <= kind;
        do @(posedge i_clk); while (!s_tready);
        n_sent++;
        case (kind)
            KIND_RX_BYTE: begin
                rx_written[rx_wp] = 1'b1;
                rx_wp++;
            end
            KIND_DISCARD: rx_rp = 8'(rx_rp + amount);
            default: ;
        endcase
    endtask

    // peek near the wanted offset, at the next entry that holds data, or send a receive byte if none does
    task automatic send_peek(input logic [7:0] want);
        logic [7:0] offset;
        int         i;
        offset = want;
        for (i = 0; i < 256 && !rx_written[8'(rx_rp + offset)]; i++)
            offset++;
        if (rx_written[8'(rx_rp + offset)])
            push_item(KIND_PEEK, rnd8(), offset, rnd8());
        else
            push_item(KIND_RX_BYTE, rnd8(), rnd8(), rnd8());
    endtask

    // one beat of unrelated traffic
    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: push_item(KIND_RX_BYTE, rnd8(), rnd8(), rnd8());
            1: send_peek(($urandom_range(0, 3) == 0) ? rnd8() : 8'($urandom_range(0, 7)));
            2: push_item(KIND_DISCARD, rnd8(), rnd8(),
                         ($urandom_range(0, 7) == 0) ? rnd8() : 8'($urandom_range(0, 4)));
            3: push_item(KIND_DATA_EMPTY, rnd8(), rnd8(), rnd8());
            default: push_item(KIND_TX_DONE, rnd8(), rnd8(), rnd8());
        endcase
    endtask

    // admit a frame, feed its bytes, then mostly drain what was queued
    task automatic send_frame();
        int len;
        int drains;
        int i;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 8);
        push_item(KIND_ADMIT, rnd8(), rnd8(), 8'(len));
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_noise();
            push_item(KIND_FRAME_BYTE, rnd8(), rnd8(), rnd8());
        end
        drains = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len)
                                              : len + $urandom_range(0, 2);
        for (i = 0; i < drains; i++)
            push_item(KIND_DATA_EMPTY, rnd8(), rnd8(), rnd8());
        if ($urandom_range(0, 3) == 0)
            push_item(KIND_TX_DONE, rnd8(), rnd8(), rnd8());
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // result side: changing stall patterns, one long hold-off mid-run
    initial begin
        int  mode;
        int  left;
        bit  held;
        mode = 0;
        left = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && n_sent >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 9) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int  pick;
        bit  paused;
        paused = 1'b0;
        foreach (rx_written[i])
            rx_written[i] = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: interrupt enables from idle, peeks with wrap, discards
        push_item(KIND_TX_DONE, rnd8(), rnd8(), rnd8());
        push_item(KIND_DATA_EMPTY, rnd8(), rnd8(), rnd8());
        push_item(KIND_RX_BYTE, 8'h00, rnd8(), rnd8());
        push_item(KIND_RX_BYTE, 8'hff, rnd8(), rnd8());
        push_item(KIND_RX_BYTE, 8'ha5, rnd8(), rnd8());
        push_item(KIND_PEEK, rnd8(), 8'd0, rnd8());
        push_item(KIND_PEEK, rnd8(), 8'd2, rnd8());
        push_item(KIND_DISCARD, rnd8(), rnd8(), 8'd1);
        push_item(KIND_PEEK, rnd8(), 8'd255, rnd8());
        push_item(KIND_DISCARD, rnd8(), rnd8(), 8'd255);
        push_item(KIND_DISCARD, rnd8(), rnd8(), 8'd0);
        push_item(KIND_PEEK, rnd8(), 8'd1, rnd8());
        // directed: stray frame byte, empty frame, admit while a frame is open
        push_item(KIND_FRAME_BYTE, 8'h5a, rnd8(), rnd8());
        push_item(KIND_ADMIT, rnd8(), rnd8(), 8'd0);
        push_item(KIND_ADMIT, rnd8(), rnd8(), 8'd2);
        push_item(KIND_ADMIT, rnd8(), rnd8(), 8'd1);
        push_item(KIND_FRAME_BYTE, 8'h11, rnd8(), rnd8());
        push_item(KIND_FRAME_BYTE, 8'hee, rnd8(), rnd8());
        push_item(KIND_TX_DONE, rnd8(), rnd8(), rnd8());
        push_item(KIND_DATA_EMPTY, rnd8(), rnd8(), rnd8());
        push_item(KIND_DATA_EMPTY, rnd8(), rnd8(), rnd8());
        push_item(KIND_TX_DONE, rnd8(), rnd8(), rnd8());
        // directed: one-byte frame leaves the transmitter busy on an empty ring
        push_item(KIND_ADMIT, rnd8(), rnd8(), 8'd1);
        push_item(KIND_FRAME_BYTE, 8'h80, rnd8(), rnd8());
        push_item(KIND_DATA_EMPTY, rnd8(), rnd8(), rnd8());

        // random: whole frames for two picks in five, the rest single operations
        while (n_sent < ITEM_COUNT) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_frame();
            else if (pick < 65)
                push_item(KIND_RX_BYTE, rnd8(), rnd8(), rnd8());
            else if (pick < 80)
                send_peek(($urandom_range(0, 3) == 0) ? rnd8() : 8'($urandom_range(0, 7)));
            else if (pick < 88)
                push_item(KIND_DISCARD, rnd8(), rnd8(),
                          ($urandom_range(0, 7) == 0) ? rnd8() : 8'($urandom_range(0, 4)));
            else if (pick < 94)
                push_item(KIND_DATA_EMPTY, rnd8(), rnd8(), rnd8());
            else if (pick < 98)
                push_item(KIND_TX_DONE, rnd8(), rnd8(), rnd8());
            else
                push_item(($urandom_range(0, 1) == 0) ? KIND_FRAME_BYTE : KIND_ADMIT,
                          rnd8(), rnd8(), rnd8());
            if (!paused && n_sent >= DRAIN_AT) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
